### rtl/mts_pkg.sv
// shared constants and types for the min tracking stack
package mts_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int VAL_W       = 32;

  localparam logic signed [VAL_W-1:0] EMPTY_MIN = {1'b0, {(VAL_W-1){1'b1}}};

  typedef enum logic [0:0] {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_OK         = 2'd0,
    ERR_PUSH_FULL  = 2'd1,
    ERR_POP_EMPTY  = 2'd2
  } err_t;

endpackage

### rtl/min_tracking_stack.sv
// min tracking stack: value and minima stacks in synchronous memories
// push, push on full and pop on empty register their result directly from ST_IDLE on acceptance;
//   a good pop first reads the entries below into val_rd_q/min_rd_q, then registers it in ST_POP
// throughput: one push per cycle while not busy; a pop holds busy in ST_POP while the read returns
// the receiver cannot stall: out_valid pulses for one cycle per item
// reset (rst_n low, synchronous) empties both stacks; memory contents are left undefined
module min_tracking_stack (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_command,
  input  logic signed [mts_pkg::VAL_W-1:0]    in_push_value,
  output logic                                out_valid,
  output logic signed [mts_pkg::VAL_W-1:0]    out_top_value,
  output logic signed [mts_pkg::VAL_W-1:0]    out_min_value,
  output logic        [mts_pkg::CNT_W-1:0]    out_entry_count,
  output logic                                out_is_empty,
  output logic        [1:0]                   out_error_code
);
  import mts_pkg::*;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_POP
  } state_t;

  // the two stacks; top entries are also cached in registers so a push needs no memory read
  logic signed [VAL_W-1:0] value_mem [STACK_DEPTH];
  logic signed [VAL_W-1:0] min_mem   [STACK_DEPTH];

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;          // entries held
  logic [CNT_W-1:0]        mcnt_r, mcnt_nxt;        // minima held
  logic signed [VAL_W-1:0] top_r, top_nxt;          // cached top entry, valid when cnt_r != 0
  logic signed [VAL_W-1:0] min_r, min_nxt;          // cached minimum, valid when mcnt_r != 0
  logic                    pop_min_r, pop_min_nxt;  // pending pop also dropped a minimum

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_top_r, out_top_nxt;
  logic signed [VAL_W-1:0] out_min_r, out_min_nxt;
  logic [CNT_W-1:0]        out_cnt_r, out_cnt_nxt;
  logic                    out_empty_r, out_empty_nxt;
  err_t                    out_err_r, out_err_nxt;

  logic                    accept;
  logic                    is_full;
  logic                    to_min;
  logic                    val_we, min_we;
  logic                    rd_en;
  logic [CNT_W-1:0]        val_rd_idx, min_rd_idx;
  logic signed [VAL_W-1:0] val_rd_q, min_rd_q;

  assign busy    = (state_r == ST_POP);
  assign accept  = start && !busy;
  assign is_full = (cnt_r == CNT_W'(STACK_DEPTH));

  // a pushed value joins the minima when there are none or it does not exceed the current one
  assign to_min  = (mcnt_r == '0) || (in_push_value <= min_r);

  assign val_we  = accept && (cmd_t'(in_command) == CMD_PUSH) && !is_full;
  assign min_we  = val_we && to_min;

  // a good pop reads the entries that become the new tops
  assign rd_en      = accept && (cmd_t'(in_command) == CMD_POP) && (cnt_r != '0);
  assign val_rd_idx = cnt_r - CNT_W'(2);
  assign min_rd_idx = mcnt_r - CNT_W'(2);

  always_ff @(posedge clk) begin
    if (val_we) begin
      value_mem[cnt_r[PTR_W-1:0]] <= in_push_value;
    end
    if (min_we) begin
      min_mem[mcnt_r[PTR_W-1:0]] <= in_push_value;
    end
    if (rd_en) begin
      val_rd_q <= value_mem[val_rd_idx[PTR_W-1:0]];
      min_rd_q <= min_mem[min_rd_idx[PTR_W-1:0]];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mcnt_nxt      = mcnt_r;
    top_nxt       = top_r;
    min_nxt       = min_r;
    pop_min_nxt   = pop_min_r;
    out_valid_nxt = 1'b0;
    out_err_nxt   = ERR_OK;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_t'(in_command) == CMD_PUSH) begin
            out_valid_nxt = 1'b1;
            if (is_full) begin
              out_err_nxt = ERR_PUSH_FULL;
            end else begin
              cnt_nxt = cnt_r + CNT_W'(1);
              top_nxt = in_push_value;
              if (to_min) begin
                mcnt_nxt = mcnt_r + CNT_W'(1);
                min_nxt  = in_push_value;
              end
            end
          end else begin
            if (cnt_r == '0) begin
              out_valid_nxt = 1'b1;
              out_err_nxt   = ERR_POP_EMPTY;
            end else begin
              // counts drop now, cached tops refresh when the read returns
              pop_min_nxt = (mcnt_r != '0) && (min_r == top_r);
              cnt_nxt     = cnt_r - CNT_W'(1);
              if ((mcnt_r != '0) && (min_r == top_r)) begin
                mcnt_nxt = mcnt_r - CNT_W'(1);
              end
              state_nxt   = ST_POP;
            end
          end
        end
      end
      ST_POP: begin
        top_nxt       = val_rd_q;
        if (pop_min_r) begin
          min_nxt = min_rd_q;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // result shows the stack after the operation
    out_cnt_nxt   = cnt_nxt;
    out_empty_nxt = (cnt_nxt == '0);
    out_top_nxt   = (cnt_nxt == '0) ? '0 : top_nxt;
    out_min_nxt   = (mcnt_nxt == '0) ? EMPTY_MIN : min_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      mcnt_r      <= '0;
      pop_min_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      mcnt_r      <= mcnt_nxt;
      pop_min_r   <= pop_min_nxt;
      out_valid_r <= out_valid_nxt;
    end
    top_r       <= top_nxt;
    min_r       <= min_nxt;
    out_top_r   <= out_top_nxt;
    out_min_r   <= out_min_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_empty_r <= out_empty_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_top_value   = out_top_r;
  assign out_min_value   = out_min_r;
  assign out_entry_count = out_cnt_r;
  assign out_is_empty    = out_empty_r;
  assign out_error_code  = out_err_r;

endmodule
